// ===== rtl/a2r_pkg.sv =====
// Shared types, constants and lookup functions for the arabic to roman emitter.
// No dependencies; imported by a2r_cmp_sub, arabic_to_roman_emitter and the testbench files.
package a2r_pkg;

	localparam int ARABIC_W      = 12;
	localparam int CHAR_W        = 8;
	localparam int DIGIT_W       = 4;
	localparam int TOTAL_W       = 5;
	localparam int LEN_W         = 3;
	localparam int MAX_RESULTS   = 15;
	localparam int MAX_THOUSANDS = 3;

	localparam logic [CHAR_W-1:0] CH_NONE = 8'h00;
	localparam logic [CHAR_W-1:0] CH_I    = 8'h49;
	localparam logic [CHAR_W-1:0] CH_V    = 8'h56;
	localparam logic [CHAR_W-1:0] CH_X    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_L    = 8'h4C;
	localparam logic [CHAR_W-1:0] CH_C    = 8'h43;
	localparam logic [CHAR_W-1:0] CH_D    = 8'h44;
	localparam logic [CHAR_W-1:0] CH_M    = 8'h4D;

	// decimal place being split off, or digit group being emitted
	typedef enum logic [1:0] {
		GRP_TH,
		GRP_HU,
		GRP_TE,
		GRP_UN
	} grp_t;

	// symbol of a digit pattern: one, five or ten of the place
	typedef enum logic [1:0] {
		SEL_ONE,
		SEL_FIVE,
		SEL_TEN
	} sel_t;

	typedef struct packed {
		logic                ge;
		logic [ARABIC_W-1:0] diff;
	} sub_res_t;

	function automatic logic [ARABIC_W-1:0] place_weight(input grp_t g);
		logic [ARABIC_W-1:0] w;
		case (g)
			GRP_TH:  w = ARABIC_W'(1000);
			GRP_HU:  w = ARABIC_W'(100);
			GRP_TE:  w = ARABIC_W'(10);
			default: w = ARABIC_W'(1);
		endcase
		return w;
	endfunction

	function automatic logic [LEN_W-1:0] digit_len(input logic [DIGIT_W-1:0] d);
		logic [LEN_W-1:0] n;
		case (d)
			4'd1, 4'd5: n = 3'd1;
			4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
			4'd3, 4'd7: n = 3'd3;
			4'd8: n = 3'd4;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic sel_t digit_pat(input logic [DIGIT_W-1:0] d, input logic [1:0] i);
		sel_t s;
		case (d)
			4'd4:    s = (i == 2'd1) ? SEL_FIVE : SEL_ONE;
			4'd9:    s = (i == 2'd1) ? SEL_TEN : SEL_ONE;
			4'd5, 4'd6, 4'd7, 4'd8: s = (i == 2'd0) ? SEL_FIVE : SEL_ONE;
			default: s = SEL_ONE;
		endcase
		return s;
	endfunction

	function automatic logic [CHAR_W-1:0] numeral_char(input grp_t g, input sel_t s);
		logic [CHAR_W-1:0] c;
		case (g)
			GRP_HU:  c = (s == SEL_ONE) ? CH_C : ((s == SEL_FIVE) ? CH_D : CH_M);
			GRP_TE:  c = (s == SEL_ONE) ? CH_X : ((s == SEL_FIVE) ? CH_L : CH_C);
			GRP_UN:  c = (s == SEL_ONE) ? CH_I : ((s == SEL_FIVE) ? CH_V : CH_X);
			default: c = CH_M;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/a2r_cmp_sub.sv =====
// Shared compare and subtract unit used to split the value into decimal places.
// Depends on a2r_pkg.
module a2r_cmp_sub
	import a2r_pkg::*;
(
	input  logic [ARABIC_W-1:0] rem,
	input  logic [ARABIC_W-1:0] weight,
	output sub_res_t            res
);

	logic [ARABIC_W:0] diff_ext;

	// borrow out of the extended subtraction means rem < weight
	assign diff_ext = {1'b0, rem} - {1'b0, weight};
	assign res.ge   = ~diff_ext[ARABIC_W];
	assign res.diff = diff_ext[ARABIC_W-1:0];

endmodule

// ===== rtl/arabic_to_roman_emitter.sv =====
// Top level: integer to roman numeral emitter, one ASCII character per output word.
// Depends on a2r_pkg and a2r_cmp_sub.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------------
//  arabic   | arabic_valid / arabic_ready | arabic_value[11:0]
//  roman    | roman_valid  / roman_ready  | roman_char[7:0], last_char,
//           |                             | empty_result, out_of_range
//
// After a word is accepted, repeated subtraction of 1000, 100 and 10 in the shared compare
// and subtract unit splits it into decimal places; then one character is emitted per cycle
// while the output is free, with a skip step for each digit group ahead of the group that
// holds the last character. A flag word is emitted after the subtraction instead.
// arabic_ready is high only while the sequencer is idle; a finished word may still sit in
// the output register then. Output stalls hold the sequencer; reset empties the output.
module arabic_to_roman_emitter
	import a2r_pkg::*;
#(
	parameter int MAX_THOUSANDS_P = MAX_THOUSANDS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                arabic_valid,
	output logic                arabic_ready,
	input  logic [ARABIC_W-1:0] arabic_value,
	output logic                roman_valid,
	input  logic                roman_ready,
	output logic [CHAR_W-1:0]   roman_char,
	output logic                last_char,
	output logic                empty_result,
	output logic                out_of_range
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT,
		ST_FLAG
	} state_t;

	state_t               state_q;
	grp_t                 grp_q;
	logic [ARABIC_W-1:0]  rem_q;
	logic [DIGIT_W-1:0]   th_q;
	logic [DIGIT_W-1:0]   hu_q;
	logic [DIGIT_W-1:0]   te_q;
	logic [DIGIT_W-1:0]   un_q;
	logic [DIGIT_W-1:0]   idx_q;
	logic [TOTAL_W-1:0]   left_q;
	logic                 flag_oor_q;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    out_char_q;
	logic                 out_last_q;
	logic                 out_empty_q;
	logic                 out_oor_q;

	sub_res_t             sub_res;
	logic [DIGIT_W-1:0]   un_d;
	logic [TOTAL_W-1:0]   total_d;
	logic                 oor_d;
	logic [DIGIT_W-1:0]   cur_d;
	logic [DIGIT_W-1:0]   cur_len;
	logic [CHAR_W-1:0]    cur_char;
	logic                 out_free;
	logic                 out_load;

	a2r_cmp_sub u_cmp_sub (
		.rem    (rem_q),
		.weight (place_weight(grp_q)),
		.res    (sub_res)
	);

	// units digit is what remains once tens are stripped
	assign un_d    = rem_q[DIGIT_W-1:0];
	assign total_d = TOTAL_W'(th_q) + TOTAL_W'(digit_len(hu_q)) + TOTAL_W'(digit_len(te_q))
		+ TOTAL_W'(digit_len(un_d));
	assign oor_d   = (th_q > DIGIT_W'(MAX_THOUSANDS_P)) || (total_d > TOTAL_W'(MAX_RESULTS));

	always_comb begin
		case (grp_q)
			GRP_HU:  cur_d = hu_q;
			GRP_TE:  cur_d = te_q;
			GRP_UN:  cur_d = un_q;
			default: cur_d = th_q;
		endcase
	end

	assign cur_len  = (grp_q == GRP_TH) ? th_q : DIGIT_W'(digit_len(cur_d));
	assign cur_char = (grp_q == GRP_TH) ? CH_M : numeral_char(grp_q, digit_pat(cur_d, idx_q[1:0]));
	assign out_free = ~out_valid_q | roman_ready;
	assign out_load = out_free && ((state_q == ST_EMIT && idx_q < cur_len) || state_q == ST_FLAG);

	assign arabic_ready = (state_q == ST_IDLE);
	assign roman_valid  = out_valid_q;
	assign roman_char   = out_char_q;
	assign last_char    = out_last_q;
	assign empty_result = out_empty_q;
	assign out_of_range = out_oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			grp_q       <= GRP_TH;
			rem_q       <= '0;
			th_q        <= '0;
			hu_q        <= '0;
			te_q        <= '0;
			un_q        <= '0;
			idx_q       <= '0;
			left_q      <= '0;
			flag_oor_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_char_q  <= CH_NONE;
			out_last_q  <= 1'b0;
			out_empty_q <= 1'b0;
			out_oor_q   <= 1'b0;
		end else begin
			// load a new output word, or drop the current one once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (roman_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (arabic_valid) begin
						rem_q   <= arabic_value;
						th_q    <= '0;
						hu_q    <= '0;
						te_q    <= '0;
						grp_q   <= GRP_TH;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (sub_res.ge) begin
						rem_q <= sub_res.diff;
						case (grp_q)
							GRP_TH:  th_q <= th_q + 1'b1;
							GRP_HU:  hu_q <= hu_q + 1'b1;
							default: te_q <= te_q + 1'b1;
						endcase
					end else if (grp_q == GRP_TE) begin
						un_q   <= un_d;
						grp_q  <= GRP_TH;
						idx_q  <= '0;
						left_q <= total_d;
						if (total_d == '0 || oor_d) begin
							flag_oor_q <= (total_d != '0);
							state_q    <= ST_FLAG;
						end else begin
							state_q <= ST_EMIT;
						end
					end else begin
						grp_q <= grp_t'(grp_q + 1'b1);
					end
				end
				ST_EMIT: begin
					if (idx_q >= cur_len) begin
						// skip to the next digit group
						grp_q <= grp_t'(grp_q + 1'b1);
						idx_q <= '0;
					end else if (out_free) begin
						out_char_q  <= cur_char;
						out_last_q  <= (left_q == TOTAL_W'(1));
						out_empty_q <= 1'b0;
						out_oor_q   <= 1'b0;
						idx_q       <= idx_q + 1'b1;
						left_q      <= left_q - 1'b1;
						if (left_q == TOTAL_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FLAG: begin
					if (out_free) begin
						out_char_q  <= CH_NONE;
						out_last_q  <= 1'b1;
						out_empty_q <= ~flag_oor_q;
						out_oor_q   <= flag_oor_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_flag_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_empty_q || out_oor_q) |-> out_char_q == CH_NONE && out_last_q)
		else $error("flag word carries a character or is not last");

	a_flag_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_empty_q && out_oor_q))
		else $error("empty and out of range both set");

	a_emit_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> left_q != '0)
		else $error("emitting with no characters left");

	a_rem_hu: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && grp_q == GRP_HU |-> rem_q < ARABIC_W'(1000))
		else $error("remainder not below 1000 while splitting hundreds");

	a_rem_te: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && grp_q == GRP_TE |-> rem_q < ARABIC_W'(100))
		else $error("remainder not below 100 while splitting tens");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		arabic_valid && arabic_ready |=> !arabic_ready)
		else $error("accepted a second word without conversion");

endmodule

// ===== tb/sv/a2r_numeral_checker.sv =====
// Checker for the arabic to roman emitter: watches both channels, spells each accepted
// value as a roman numeral and compares every output word against that spelling.
// Depends on a2r_pkg for widths and character codes.
module a2r_numeral_checker
	import a2r_pkg::*;
#(
	parameter int THOUSANDS_LIMIT = MAX_THOUSANDS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                arabic_valid,
	input  logic                arabic_ready,
	input  logic [ARABIC_W-1:0] arabic_value,
	input  logic                roman_valid,
	input  logic                roman_ready,
	input  logic [CHAR_W-1:0]   roman_char,
	input  logic                last_char,
	input  logic                empty_result,
	input  logic                out_of_range,
	output int                  fail_count,
	output int                  words_due
);

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              empty;
		logic              oor;
	} roman_word_t;

	roman_word_t       numeral_q[$];
	logic [CHAR_W-1:0] char_seq[$];
	roman_word_t       want;
	roman_word_t       got;

	initial begin
		fail_count = 0;
		words_due  = 0;
	end

	// append the subtractive pattern of one decimal digit
	function automatic void add_digit(input int d, input logic [CHAR_W-1:0] one,
		input logic [CHAR_W-1:0] five, input logic [CHAR_W-1:0] ten);
		int i;
		if (d == 4) begin
			char_seq.push_back(one);
			char_seq.push_back(five);
		end else if (d == 9) begin
			char_seq.push_back(one);
			char_seq.push_back(ten);
		end else begin
			if (d >= 5)
				char_seq.push_back(five);
			for (i = 0; i < d % 5; i++)
				char_seq.push_back(one);
		end
	endfunction

	function automatic void spell_numeral(input logic [ARABIC_W-1:0] v);
		int          n;
		int          i;
		roman_word_t w;
		n = int'(v);
		char_seq.delete();
		if (n == 0) begin
			w = '{ch: CH_NONE, last: 1'b1, empty: 1'b1, oor: 1'b0};
			numeral_q.push_back(w);
			return;
		end
		for (i = 0; i < n / 1000; i++)
			char_seq.push_back(CH_M);
		add_digit((n % 1000) / 100, CH_C, CH_D, CH_M);
		add_digit((n % 100) / 10, CH_X, CH_L, CH_C);
		add_digit(n % 10, CH_I, CH_V, CH_X);
		// a run that cannot fit is flagged like a value above the bound
		if (n > THOUSANDS_LIMIT * 1000 + 999 || char_seq.size() > MAX_RESULTS) begin
			w = '{ch: CH_NONE, last: 1'b1, empty: 1'b0, oor: 1'b1};
			numeral_q.push_back(w);
			return;
		end
		for (i = 0; i < char_seq.size(); i++) begin
			w = '{ch: char_seq[i], last: (i == char_seq.size() - 1), empty: 1'b0, oor: 1'b0};
			numeral_q.push_back(w);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (roman_valid && roman_ready) begin
				got = '{ch: roman_char, last: last_char, empty: empty_result,
					oor: out_of_range};
				if (numeral_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected roman word: char %h last %b empty %b oor %b",
							got.ch, got.last, got.empty, got.oor);
					fail_count++;
				end else begin
					want = numeral_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("roman word mismatch: expected char %h last %b empty %b oor %b, got char %h last %b empty %b oor %b",
								want.ch, want.last, want.empty, want.oor,
								got.ch, got.last, got.empty, got.oor);
						fail_count++;
					end
				end
			end
			if (arabic_valid && arabic_ready)
				spell_numeral(arabic_value);
			words_due = numeral_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_arabic_to_roman_emitter.sv =====
// Testbench top for arabic_to_roman_emitter: drives values and output stalls in phases.
// Depends on a2r_pkg, the emitter RTL and a2r_numeral_checker.
module tb_arabic_to_roman_emitter;
	import a2r_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int PHASE_WORDS  = 80;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 60;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                arabic_valid = 1'b0;
	logic                arabic_ready;
	logic [ARABIC_W-1:0] arabic_value = '0;
	logic                roman_valid;
	logic                roman_ready  = 1'b0;
	logic [CHAR_W-1:0]   roman_char;
	logic                last_char;
	logic                empty_result;
	logic                out_of_range;

	int fail_count;
	int words_due;
	int snd_idle_pct  = 0;
	int rcv_stall_pct = 0;
	int hold_cnt      = 0;
	int cycle_cnt     = 0;
	bit hold_go       = 1'b0;

	int snd_pct_tbl[4] = '{0, 47, 0, 17};
	int rcv_pct_tbl[4] = '{0, 0, 47, 17};
	int directed_vals[22] = '{0, 1, 4095, 3999, 4000, 3888, 4, 5, 8, 9, 40, 90,
		400, 900, 1000, 3000, 10, 100, 50, 500, 1994, 2730};

	arabic_to_roman_emitter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.arabic_valid (arabic_valid),
		.arabic_ready (arabic_ready),
		.arabic_value (arabic_value),
		.roman_valid  (roman_valid),
		.roman_ready  (roman_ready),
		.roman_char   (roman_char),
		.last_char    (last_char),
		.empty_result (empty_result),
		.out_of_range (out_of_range)
	);

	a2r_numeral_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.arabic_valid (arabic_valid),
		.arabic_ready (arabic_ready),
		.arabic_value (arabic_value),
		.roman_valid  (roman_valid),
		.roman_ready  (roman_ready),
		.roman_char   (roman_char),
		.last_char    (last_char),
		.empty_result (empty_result),
		.out_of_range (out_of_range),
		.fail_count   (fail_count),
		.words_due    (words_due)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("arabic_to_roman_emitter test failed");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_go) begin
			hold_go  = 1'b0;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			roman_ready <= 1'b0;
		end else begin
			roman_ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	function automatic logic [ARABIC_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 13)
			return ARABIC_W'($urandom_range(4095, 4000));
		if (r < 30)
			return ARABIC_W'($urandom_range(99, 1));
		if (r < 45)
			return ARABIC_W'($urandom_range(3999, 3000));
		return ARABIC_W'($urandom_range(3999, 1));
	endfunction

	task automatic offer_word(input logic [ARABIC_W-1:0] v);
		while ($urandom_range(99) < snd_idle_pct) begin
			@(negedge clk);
			arabic_valid <= 1'b0;
		end
		@(negedge clk);
		arabic_valid <= 1'b1;
		arabic_value <= v;
		do @(posedge clk); while (!arabic_ready);
	endtask

	// drop valid and hold off until every expected word has come out
	task automatic drain_words();
		@(negedge clk);
		arabic_valid <= 1'b0;
		wait (words_due == 0);
	endtask

	initial begin
		int ph;
		int i;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < 22; i++)
			offer_word(ARABIC_W'(directed_vals[i]));
		drain_words();

		for (ph = 0; ph < 4; ph++) begin
			snd_idle_pct  = snd_pct_tbl[ph];
			rcv_stall_pct = rcv_pct_tbl[ph];
			for (i = 0; i < PHASE_WORDS; i++) begin
				// stall the output long enough to back up the input
				if (ph == 0 && i == 10)
					hold_go = 1'b1;
				offer_word(pick_value());
			end
			drain_words();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && words_due == 0) begin
			$display("arabic_to_roman_emitter test passed");
		end else begin
			$display("arabic_to_roman_emitter test failed");
		end
		$finish;
	end

endmodule

// ===== arabic_to_roman_emitter.f =====
rtl/a2r_pkg.sv
rtl/a2r_cmp_sub.sv
rtl/arabic_to_roman_emitter.sv
tb/sv/a2r_numeral_checker.sv
tb/sv/tb_arabic_to_roman_emitter.sv
